// ----- rtl/core/fpa_pkg.sv -----
// Package for the fixed-point ALU: operation codes, widths and the shared pipeline word type.
`timescale 1ns / 1ps
package fpa_pkg;

    localparam int unsigned DATA_W        = 32;
    localparam int unsigned DEF_FRAC_BITS = 8;
    localparam int unsigned NUM_W         = 48;  // |A| * 2^16 fits
    localparam int unsigned OP_W          = 4;

    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_GT   = 4'd4,
        OP_LT   = 4'd5,
        OP_GE   = 4'd6,
        OP_LE   = 4'd7,
        OP_EQ   = 4'd8,
        OP_NE   = 4'd9,
        OP_INC  = 4'd10,
        OP_DEC  = 4'd11,
        OP_FINT = 4'd12,
        OP_TINT = 4'd13
    } t_op;

    // One word traveling down the cell chain.
    typedef struct packed {
        logic              vld;
        logic              is_div;
        logic              neg;     // quotient sign
        logic              dz;
        logic              cmp;
        logic [DATA_W-1:0] res;     // result for non-divide words
        logic [NUM_W-1:0]  rem;     // partial remainder
        logic [NUM_W-1:0]  num;     // dividend bits still to shift in, msb first
        logic [DATA_W-1:0] den;     // |B|
        logic [NUM_W-1:0]  quo;
    } t_word;

endpackage

// ----- rtl/core/fpa_front.sv -----
// Front stage: decodes the operation, computes every non-divide result and prepares the divide.
`timescale 1ns / 1ps
module fpa_front
    import fpa_pkg::*;
#(
    parameter int unsigned FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [OP_W-1:0]   i_op,
    input  logic [DATA_W-1:0] i_a,
    input  logic [DATA_W-1:0] i_b,
    output t_word             o_word
);

    t_word r_word;
    t_word n_word;

    logic signed [2*DATA_W-1:0] w_prod;
    logic signed [2*DATA_W-1:0] w_prod_adj;
    logic signed [DATA_W-1:0]   w_sa;
    logic signed [DATA_W-1:0]   w_sb;
    logic [DATA_W-1:0]          w_abs_a;
    logic [DATA_W-1:0]          w_abs_b;

    assign w_sa    = i_a;
    assign w_sb    = i_b;
    assign w_abs_a = w_sa[DATA_W-1] ? (~i_a + 1'b1) : i_a;
    assign w_abs_b = w_sb[DATA_W-1] ? (~i_b + 1'b1) : i_b;

    // Product truncated toward zero: bias negatives before the shift.
    assign w_prod     = w_sa * w_sb;
    assign w_prod_adj = w_prod + (w_prod[2*DATA_W-1]
                        ? {{(2*DATA_W-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}}
                        : '0);

    // Decode
    always_comb begin
        n_word        = '0;
        n_word.vld    = i_vld;
        n_word.den    = w_abs_b;
        n_word.num    = {{(NUM_W-DATA_W){1'b0}}, w_abs_a} << FRAC_BITS;
        n_word.neg    = w_sa[DATA_W-1] ^ w_sb[DATA_W-1];
        unique case (i_op)
            OP_ADD:  n_word.res = i_a + i_b;
            OP_SUB:  n_word.res = i_a - i_b;
            OP_MUL:  n_word.res = w_prod_adj[FRAC_BITS +: DATA_W];
            OP_DIV: begin
                n_word.is_div = (i_b != '0);
                n_word.dz     = (i_b == '0);
            end
            OP_GT:   n_word.cmp = (w_sa >  w_sb);
            OP_LT:   n_word.cmp = (w_sa <  w_sb);
            OP_GE:   n_word.cmp = (w_sa >= w_sb);
            OP_LE:   n_word.cmp = (w_sa <= w_sb);
            OP_EQ:   n_word.cmp = (i_a == i_b);
            OP_NE:   n_word.cmp = (i_a != i_b);
            OP_INC:  n_word.res = i_a + 1'b1;
            OP_DEC:  n_word.res = i_a - 1'b1;
            OP_FINT: n_word.res = i_a << FRAC_BITS;
            OP_TINT: n_word.res = DATA_W'(w_sa >>> FRAC_BITS);
            default: n_word.res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.vld <= 1'b0;
        end else begin
            r_word.vld <= n_word.vld;
        end
        {r_word.is_div, r_word.neg, r_word.dz, r_word.cmp, r_word.res,
         r_word.rem, r_word.num, r_word.den, r_word.quo} <=
        {n_word.is_div, n_word.neg, n_word.dz, n_word.cmp, n_word.res,
         n_word.rem, n_word.num, n_word.den, n_word.quo};
    end

    assign o_word = r_word;

endmodule

// ----- rtl/core/fpa_cell.sv -----
// Divider cell: one restoring-division step per cell, word handed on each cycle.
`timescale 1ns / 1ps
module fpa_cell
    import fpa_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_word i_word,
    output t_word o_word
);

    t_word               r_word;
    t_word               n_word;
    logic [NUM_W-1:0]    w_trial;
    logic [NUM_W:0]      w_diff;

    // One quotient bit
    always_comb begin
        n_word   = i_word;
        w_trial  = {i_word.rem[NUM_W-2:0], i_word.num[NUM_W-1]};
        w_diff   = {1'b0, w_trial} - {{(NUM_W+1-DATA_W){1'b0}}, i_word.den};
        n_word.num = {i_word.num[NUM_W-2:0], 1'b0};
        if (i_word.is_div) begin
            n_word.rem = w_diff[NUM_W] ? w_trial : w_diff[NUM_W-1:0];
            n_word.quo = {i_word.quo[NUM_W-2:0], ~w_diff[NUM_W]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.vld <= 1'b0;
        end else begin
            r_word.vld <= n_word.vld;
        end
        {r_word.is_div, r_word.neg, r_word.dz, r_word.cmp, r_word.res,
         r_word.rem, r_word.num, r_word.den, r_word.quo} <=
        {n_word.is_div, n_word.neg, n_word.dz, n_word.cmp, n_word.res,
         n_word.rem, n_word.num, n_word.den, n_word.quo};
    end

    assign o_word = r_word;

endmodule

// ----- rtl/core/fixed_point_alu_core.sv -----
// Top level of the fixed-point ALU: front stage, divider cell chain and output register.
// Path from start to o_valid: front stage, 48 divider cells, output stage.
// Throughput: one word per cycle; busy stays low, a new word may start every cycle.
// Every operation takes the same path so results leave in order.
// Reset: synchronous active-low i_rst_n clears all valid bits; no word in flight survives.
// The receiver cannot stall; each result shows for one cycle with o_valid.
`timescale 1ns / 1ps
module fixed_point_alu_core
    import fpa_pkg::*;
#(
    parameter int unsigned FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [OP_W-1:0]          i_operation,
    input  logic signed [DATA_W-1:0] i_operand_a,
    input  logic signed [DATA_W-1:0] i_operand_b,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_result_value,
    output logic                     o_compare_true,
    output logic                     o_divide_by_zero
);

    t_word w_chain [NUM_W+1];

    logic                r_valid;
    logic [DATA_W-1:0]   r_result;
    logic                r_cmp;
    logic                r_dz;
    logic [DATA_W-1:0]   n_result;
    logic [DATA_W-1:0]   w_q;
    t_word               w_last;

    assign busy = 1'b0;

    fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start),
        .i_op    (i_operation),
        .i_a     (i_operand_a),
        .i_b     (i_operand_b),
        .o_word  (w_chain[0])
    );

    // Divider chain, one quotient bit per cell
    for (genvar g = 0; g < NUM_W; g++) begin : g_cell
        fpa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_word  (w_chain[g]),
            .o_word  (w_chain[g+1])
        );
    end

    assign w_last = w_chain[NUM_W];
    assign w_q    = w_last.quo[DATA_W-1:0];

    // Apply quotient sign, wrap to 32 bits
    always_comb begin
        if (w_last.is_div) begin
            n_result = w_last.neg ? (~w_q + 1'b1) : w_q;
        end else begin
            n_result = w_last.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_last.vld;
        end
        r_result <= n_result;
        r_cmp    <= w_last.cmp;
        r_dz     <= w_last.dz;
    end

    assign o_valid          = r_valid;
    assign o_result_value   = r_result;
    assign o_compare_true   = r_cmp;
    assign o_divide_by_zero = r_dz;

endmodule

// ----- rtl/core/fpa_checker.sv -----
// Port-level checker for the fixed-point ALU, bound to the top level.
`timescale 1ns / 1ps
module fpa_checker
    import fpa_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_valid,
    input logic [DATA_W-1:0] o_result_value,
    input logic              o_compare_true,
    input logic              o_divide_by_zero
);

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_compare_true && o_divide_by_zero))
        else $error("compare and divide flags both set");

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divide_by_zero) |-> (o_result_value == '0))
        else $error("divide by zero with nonzero result");

    a_cmp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_compare_true) |-> (o_result_value == '0))
        else $error("comparison with nonzero result");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##50 o_valid)
        else $error("result missing after pipeline latency");

endmodule

bind fixed_point_alu_core fpa_checker u_fpa_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_valid          (o_valid),
    .o_result_value   (o_result_value),
    .o_compare_true   (o_compare_true),
    .o_divide_by_zero (o_divide_by_zero)
);

// ----- test/tb_fixed_point_alu_core.sv -----
// Self-checking testbench for the fixed-point ALU core: random and directed words, in order.
`timescale 1ns / 1ps
module tb_fixed_point_alu_core;
    import fpa_pkg::*;

    localparam int FRAC       = DEF_FRAC_BITS;
    localparam int LATENCY    = 50;
    localparam int IDLE_LIMIT = 2000;
    localparam int N_RANDOM   = 1550;

    typedef struct {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
    } t_cmd;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic                     cmp;
        logic                     dz;
    } t_alu_out;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic [OP_W-1:0]          i_operation;
    logic signed [DATA_W-1:0] i_operand_a;
    logic signed [DATA_W-1:0] i_operand_b;
    logic                     o_valid;
    logic signed [DATA_W-1:0] o_result_value;
    logic                     o_compare_true;
    logic                     o_divide_by_zero;

    t_cmd     cmd_q[$];
    t_alu_out alu_out_q[$];
    int       error_cnt;
    int       idle_cycles;
    bit       gen_done;
    bit       hold_off;
    bit       quiet_stretch;

    fixed_point_alu_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_operand_a     (i_operand_a),
        .i_operand_b     (i_operand_b),
        .o_valid         (o_valid),
        .o_result_value  (o_result_value),
        .o_compare_true  (o_compare_true),
        .o_divide_by_zero(o_divide_by_zero)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Expected ALU output for one command word
    function automatic t_alu_out alu_predict(t_cmd c);
        t_alu_out          r;
        logic signed [63:0] a64;
        logic signed [63:0] b64;
        logic signed [63:0] t;
        a64 = c.a;
        b64 = c.b;
        r.value = '0;
        r.cmp = 1'b0;
        r.dz = 1'b0;
        case (c.op)
            OP_ADD:  r.value = c.a + c.b;
            OP_SUB:  r.value = c.a - c.b;
            OP_MUL: begin
                t = (a64 * b64) / (64'sd1 <<< FRAC);
                r.value = t[31:0];
            end
            OP_DIV: begin
                if (c.b == 0) begin
                    r.dz = 1'b1;
                end else begin
                    t = (a64 * (64'sd1 <<< FRAC)) / b64;
                    r.value = t[31:0];
                end
            end
            OP_GT:   r.cmp = c.a > c.b;
            OP_LT:   r.cmp = c.a < c.b;
            OP_GE:   r.cmp = c.a >= c.b;
            OP_LE:   r.cmp = c.a <= c.b;
            OP_EQ:   r.cmp = c.a == c.b;
            OP_NE:   r.cmp = c.a != c.b;
            OP_INC:  r.value = c.a + 1;
            OP_DEC:  r.value = c.a - 1;
            OP_FINT: r.value = c.a <<< FRAC;
            OP_TINT: r.value = c.a >>> FRAC;
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return '0;
            3: return $signed($urandom_range(0, 2047)) - 1024;
            4: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_cmd(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] a,
                            logic signed [DATA_W-1:0] b);
        t_cmd c;
        c.op = op;
        c.a = a;
        c.b = b;
        cmd_q.push_back(c);
    endtask

    // Stimulus
    initial begin
        gen_done = 1'b0;
        hold_off = 1'b0;
        for (int op = 0; op < 16; op++) begin
            push_cmd(OP_W'(op), 32'sh7fffffff, 32'sh80000000);
            if (op < 10) push_cmd(OP_W'(op), 32'sh80000000, 32'sh80000000);
        end
        push_cmd(OP_DIV, 32'sh00000300, 32'sh0);
        push_cmd(OP_DIV, 32'shfffffd00, 32'sh00000200);
        push_cmd(OP_MUL, 32'shffffff01, 32'sh00000080);
        push_cmd(OP_TINT, 32'shffffff01, 32'sh0);
        wait (cmd_q.size() == 0);
        // Drain everything once before the random phase
        hold_off = 1'b1;
        wait (alu_out_q.size() == 0);
        hold_off = 1'b0;
        for (int i = 0; i < N_RANDOM; i++) begin
            logic signed [DATA_W-1:0] b;
            b = rand_operand();
            if ($urandom_range(0, 15) == 0) b = '0;
            push_cmd(OP_W'($urandom_range(0, 15)), rand_operand(), b);
            if (cmd_q.size() > 64) wait (cmd_q.size() < 32);
        end
        gen_done = 1'b1;
    end

    // Driver: drop the word accepted at the last rising edge, then offer the next one
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            quiet_stretch <= 1'b0;
            i_operation <= '0;
            i_operand_a <= '0;
            i_operand_b <= '0;
        end else begin
            if (start && !busy) void'(cmd_q.pop_front());
            if ($urandom_range(0, 299) == 0) quiet_stretch <= ~quiet_stretch;
            if (cmd_q.size() > 0 && !hold_off &&
                (quiet_stretch || $urandom_range(0, 99) >= 32)) begin
                start <= 1'b1;
                i_operation <= cmd_q[0].op;
                i_operand_a <= cmd_q[0].a;
                i_operand_b <= cmd_q[0].b;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: record accepted words and check results in order
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if ((start && !busy) || o_valid) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (start && !busy) begin
                t_cmd c;
                c.op = i_operation;
                c.a = i_operand_a;
                c.b = i_operand_b;
                alu_out_q.push_back(alu_predict(c));
            end
            if (o_valid) begin
                if (alu_out_q.size() == 0) begin
                    $error("result with no word pending");
                    error_cnt++;
                end else begin
                    t_alu_out e;
                    e = alu_out_q.pop_front();
                    if (o_result_value !== e.value) begin
                        $error("result_value exp %h got %h", e.value, o_result_value);
                        error_cnt++;
                    end
                    if (o_compare_true !== e.cmp) begin
                        $error("compare_true exp %b got %b", e.cmp, o_compare_true);
                        error_cnt++;
                    end
                    if (o_divide_by_zero !== e.dz) begin
                        $error("divide_by_zero exp %b got %b", e.dz, o_divide_by_zero);
                        error_cnt++;
                    end
                end
            end
        end
    end

    // Reset, watchdog and end of run
    initial begin
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (!(gen_done && cmd_q.size() == 0 && alu_out_q.size() == 0) &&
               idle_cycles < IDLE_LIMIT)
            @(posedge i_clk);
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL fixed_point_alu_core");
        end else begin
            repeat (LATENCY + 10) @(posedge i_clk);
            if (error_cnt == 0 && alu_out_q.size() == 0)
                $display("PASS fixed_point_alu_core");
            else
                $display("FAIL fixed_point_alu_core");
        end
        $finish;
    end

endmodule
